>>> hw/rtl/ffha_pkg.sv
package ffha_pkg;

	localparam int HOLE_SLOTS = 16;
	localparam int SWAP_PAGES = 1024;

	localparam int OP_W    = 2;
	localparam int START_W = 10;
	localparam int LEN_W   = 11;
	localparam int SLOT_W  = $clog2(HOLE_SLOTS);
	localparam int CNT_W   = $clog2(HOLE_SLOTS + 1);
	localparam int SUM_W   = LEN_W + SLOT_W;

	localparam int IN_BITS  = OP_W + START_W + LEN_W;
	localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_BITS = 1 + START_W + LEN_W + 1;
	localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

	typedef enum logic [OP_W-1:0] {
		OP_APPEND = 2'd0,
		OP_ALLOC  = 2'd1,
		OP_QUERY  = 2'd2
	} opcode_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_SCAN,
		ST_COMMIT,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic capture;
		logic append;
		logic scan_next;
		logic commit;
		logic finish;
	} cmd_t;

	typedef struct packed {
		opcode_t          op;
		logic             scan_end;
		logic             scan_hit;
		logic             out_free;
		logic [CNT_W-1:0] hole_cnt;
	} stat_t;

endpackage

>>> hw/rtl/ffha_dp.sv
module ffha_dp (
	input  logic                        clk,
	input  logic                        arst_n,
	input  ffha_pkg::cmd_t              cmd,
	input  logic [ffha_pkg::IN_W-1:0]   s_tdata,
	input  logic                        m_tready,
	output ffha_pkg::stat_t             stat,
	output logic                        m_tvalid,
	output logic [ffha_pkg::OUT_W-1:0]  m_tdata
);

	localparam int START_W = ffha_pkg::START_W;
	localparam int LEN_W   = ffha_pkg::LEN_W;
	localparam int SLOT_W  = ffha_pkg::SLOT_W;
	localparam int CNT_W   = ffha_pkg::CNT_W;
	localparam int SUM_W   = ffha_pkg::SUM_W;
	localparam int N       = ffha_pkg::HOLE_SLOTS;

	logic [START_W-1:0] start_tab_q [N];
	logic [LEN_W-1:0]   len_tab_q [N];

	ffha_pkg::opcode_t  op_q;
	logic [START_W-1:0] start_in_q;
	logic [LEN_W-1:0]   req_q;
	logic [CNT_W-1:0]   idx_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [SUM_W-1:0]   sum_q;
	logic               res_granted_q;
	logic [START_W-1:0] res_start_q;
	logic               res_ovf_q;
	logic               m_tvalid_q;
	logic [ffha_pkg::OUT_W-1:0] m_tdata_q;

	logic [START_W-1:0] cur_start;
	logic [LEN_W-1:0]   cur_len;
	logic [LEN_W-1:0]   rem;
	logic [START_W-1:0] rem_start;
	logic               full;
	logic [CNT_W-1:0]   last;
	logic [LEN_W-1:0]   total;

	assign cur_start = start_tab_q[idx_q[SLOT_W-1:0]];
	assign cur_len   = len_tab_q[idx_q[SLOT_W-1:0]];
	assign rem       = cur_len - req_q;
	assign rem_start = cur_start + req_q[START_W-1:0];
	assign full      = (cnt_q == CNT_W'(N));
	assign last      = cnt_q - CNT_W'(1);
	assign total     = (32'(sum_q) > 32'(ffha_pkg::SWAP_PAGES))
		? LEN_W'(ffha_pkg::SWAP_PAGES) : LEN_W'(sum_q);

	always_comb begin
		stat.op       = op_q;
		stat.scan_end = (idx_q >= cnt_q);
		stat.scan_hit = (cur_len >= req_q);
		stat.out_free = !m_tvalid_q || m_tready;
		stat.hole_cnt = cnt_q;
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= '0;
			sum_q      <= '0;
			idx_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cmd.capture) begin
				idx_q <= '0;
			end else if (cmd.scan_next) begin
				idx_q <= idx_q + CNT_W'(1);
			end
			if (cmd.append && !full) begin
				cnt_q <= cnt_q + CNT_W'(1);
				sum_q <= sum_q + SUM_W'(req_q);
			end else if (cmd.commit) begin
				cnt_q <= (rem != '0) ? cnt_q : last;
				sum_q <= sum_q - SUM_W'(req_q);
			end
			if (cmd.finish) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q          <= ffha_pkg::opcode_t'(s_tdata[ffha_pkg::OP_W-1:0]);
			start_in_q    <= s_tdata[ffha_pkg::OP_W +: START_W];
			req_q         <= s_tdata[ffha_pkg::OP_W + START_W +: LEN_W];
			res_granted_q <= 1'b0;
			res_start_q   <= '0;
			res_ovf_q     <= 1'b0;
		end
		if (cmd.append) begin
			res_ovf_q <= full;
		end
		if (cmd.commit) begin
			res_granted_q <= 1'b1;
			res_start_q   <= cur_start;
		end
		if (cmd.finish) begin
			m_tdata_q <= ffha_pkg::OUT_W'({res_ovf_q, total, res_start_q, res_granted_q});
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < N; k++) begin
			if (cmd.append && !full && CNT_W'(k) == cnt_q) begin
				start_tab_q[k] <= start_in_q;
				len_tab_q[k]   <= req_q;
			end else if (cmd.commit) begin
				if (rem != '0 && CNT_W'(k) == last) begin
					start_tab_q[k] <= rem_start;
					len_tab_q[k]   <= rem;
				end else if (k < N - 1 && CNT_W'(k) >= idx_q
						&& CNT_W'(k + 1) < cnt_q) begin
					start_tab_q[k] <= start_tab_q[(k + 1) % N];
					len_tab_q[k]   <= len_tab_q[(k + 1) % N];
				end
			end
		end
	end

endmodule

>>> hw/rtl/ffha_ctrl.sv
module ffha_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	input  ffha_pkg::stat_t stat,
	output logic            s_tready,
	output ffha_pkg::cmd_t  cmd
);

	ffha_pkg::state_t state_q;
	ffha_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ffha_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ffha_pkg::ST_IDLE: begin
				if (s_tvalid) state_d = ffha_pkg::ST_DECODE;
			end
			ffha_pkg::ST_DECODE: begin
				if (stat.op == ffha_pkg::OP_ALLOC) state_d = ffha_pkg::ST_SCAN;
				else state_d = ffha_pkg::ST_FINISH;
			end
			ffha_pkg::ST_SCAN: begin
				if (stat.scan_end) state_d = ffha_pkg::ST_FINISH;
				else if (stat.scan_hit) state_d = ffha_pkg::ST_COMMIT;
			end
			ffha_pkg::ST_COMMIT: begin
				state_d = ffha_pkg::ST_FINISH;
			end
			ffha_pkg::ST_FINISH: begin
				if (stat.out_free) state_d = ffha_pkg::ST_IDLE;
			end
			default: begin
				state_d = ffha_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd      = '0;
		s_tready = 1'b0;
		case (state_q)
			ffha_pkg::ST_IDLE: begin
				s_tready    = 1'b1;
				cmd.capture = s_tvalid;
			end
			ffha_pkg::ST_DECODE: begin
				cmd.append = (stat.op == ffha_pkg::OP_APPEND);
			end
			ffha_pkg::ST_SCAN: begin
				cmd.scan_next = !stat.scan_end && !stat.scan_hit;
			end
			ffha_pkg::ST_COMMIT: begin
				cmd.commit = 1'b1;
			end
			ffha_pkg::ST_FINISH: begin
				cmd.finish = stat.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

>>> hw/rtl/first_fit_page_hole_allocator_top.sv
// Channel  Dir  Signals                      Word
// s        in   s_tvalid s_tready s_tdata    opcode, hole_start_in, page_count
// m        out  m_tvalid m_tready m_tdata    granted, granted_start, total_free_pages,
//                                            table_overflow
//
// Append and query words pass through the decode and finish states; allocate
// also scans the hole table one slot a cycle and, on a hit, passes through the
// commit state before finish. One word is in work at a time; the
// result register lets the next word be accepted while a result waits.
// Reset empties the hole table at once. A stalled m side holds the controller
// in its finish state.
module first_fit_page_hole_allocator_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [ffha_pkg::IN_W-1:0]   s_tdata,   // opcode, hole_start_in, page_count
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [ffha_pkg::OUT_W-1:0]  m_tdata    // granted, granted_start,
	                                               // total_free_pages, table_overflow
);

	ffha_pkg::cmd_t  cmd;
	ffha_pkg::stat_t stat;

	ffha_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.stat     (stat),
		.s_tready (s_tready),
		.cmd      (cmd)
	);

	ffha_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.s_tdata  (s_tdata),
		.m_tready (m_tready),
		.stat     (stat),
		.m_tvalid (m_tvalid),
		.m_tdata  (m_tdata)
	);

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		stat.hole_cnt <= ffha_pkg::CNT_W'(ffha_pkg::HOLE_SLOTS))
		else $error("hole count past table size");

	a_one_in_work: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second word taken while one in work");

	a_grant_no_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[0] |-> !m_tdata[ffha_pkg::OUT_BITS-1])
		else $error("grant reported with overflow");

	a_nogrant_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[0] |-> m_tdata[ffha_pkg::START_W:1] == '0)
		else $error("start nonzero without grant");

endmodule

>>> tb/tb_first_fit_page_hole_allocator_top.sv
module tb_first_fit_page_hole_allocator_top;
	timeunit 1ns;
	timeprecision 1ps;

	import ffha_pkg::*;

	localparam int RANDOM_WORDS = 1100;
	localparam int CYCLE_LIMIT  = 900000;

	typedef struct {
		logic               granted;
		logic [START_W-1:0] gstart;
		logic [LEN_W-1:0]   free_pages;
		logic               overflow;
	} page_result_t;

	class hole_ledger;
		logic [START_W-1:0] starts [HOLE_SLOTS];
		logic [LEN_W-1:0]   lengths [HOLE_SLOTS];
		int                 hole_count;
		page_result_t       pending_results [$];
		int                 errors;

		function new();
			hole_count = 0;
			errors = 0;
		endfunction

		function void report(string msg);
			errors++;
			if (errors <= 40) begin
				$display("mismatch at %0t: %s", $realtime, msg);
			end
		endfunction

		function bit push_hole(logic [START_W-1:0] s, logic [LEN_W-1:0] l);
			if (hole_count >= HOLE_SLOTS) begin
				return 1'b0;
			end
			starts[hole_count] = s;
			lengths[hole_count] = l;
			hole_count++;
			return 1'b1;
		endfunction

		function void note_word(opcode_t op, logic [START_W-1:0] st, logic [LEN_W-1:0] cnt);
			page_result_t       r;
			int                 idx;
			bit                 hit;
			logic [START_W-1:0] s0;
			logic [LEN_W-1:0]   l0;
			int                 sum;
			r.granted = 1'b0;
			r.gstart = '0;
			r.overflow = 1'b0;
			case (op)
				OP_APPEND: begin
					if (!push_hole(st, cnt)) begin
						r.overflow = 1'b1;
					end
				end
				OP_ALLOC: begin
					idx = 0;
					hit = 1'b0;
					while (!hit && idx < hole_count) begin
						if (lengths[idx] >= cnt) begin
							hit = 1'b1;
						end else begin
							idx++;
						end
					end
					if (hit) begin
						s0 = starts[idx];
						l0 = lengths[idx];
						for (int j = idx; j + 1 < hole_count; j++) begin
							starts[j] = starts[j + 1];
							lengths[j] = lengths[j + 1];
						end
						hole_count--;
						if (l0 != cnt) begin
							if (!push_hole(START_W'(s0 + cnt), l0 - cnt)) begin
								r.overflow = 1'b1;
							end
						end
						r.granted = 1'b1;
						r.gstart = s0;
					end
				end
				default: begin
				end
			endcase
			sum = 0;
			for (int i = 0; i < hole_count; i++) begin
				sum += lengths[i];
			end
			if (sum > SWAP_PAGES) begin
				sum = SWAP_PAGES;
			end
			r.free_pages = LEN_W'(sum);
			pending_results.push_back(r);
		endfunction

		function void check_word(logic [OUT_W-1:0] w);
			page_result_t exp;
			if (pending_results.size() == 0) begin
				report($sformatf("unexpected result word %h", w));
				return;
			end
			exp = pending_results.pop_front();
			if (w[0] !== exp.granted) begin
				report($sformatf("granted %b, want %b", w[0], exp.granted));
			end
			if (w[START_W:1] !== exp.gstart) begin
				report($sformatf("granted_start %0d, want %0d", w[START_W:1], exp.gstart));
			end
			if (w[START_W+LEN_W:START_W+1] !== exp.free_pages) begin
				report($sformatf("total_free_pages %0d, want %0d",
					w[START_W+LEN_W:START_W+1], exp.free_pages));
			end
			if (w[START_W+LEN_W+1] !== exp.overflow) begin
				report($sformatf("table_overflow %b, want %b",
					w[START_W+LEN_W+1], exp.overflow));
			end
		endfunction
	endclass

	logic            clk = 1'b0;
	logic            arst_n = 1'b0;
	logic            s_tvalid = 1'b0;
	logic            s_tready;
	logic [IN_W-1:0] s_tdata = '0;
	logic            m_tvalid;
	logic            m_tready = 1'b0;
	logic [OUT_W-1:0] m_tdata;

	hole_ledger ledger;
	bit         quiet = 1'b0;
	int         stall_left = 0;
	int         cycles = 0;

	first_fit_page_hole_allocator_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function int pick_idle_len();
		int r;
		if (quiet) begin
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 55) begin
			return 0;
		end else if (r < 90) begin
			return $urandom_range(1, 3);
		end else if (r < 98) begin
			return $urandom_range(4, 10);
		end
		return $urandom_range(20, 60);
	endfunction

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	always @(posedge clk) begin
		int stall;
		if (arst_n && m_tvalid && m_tready) begin
			ledger.check_word(m_tdata);
		end
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			m_tready <= 1'b0;
		end else begin
			stall = pick_idle_len();
			if (stall > 0) begin
				stall_left <= stall - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	task automatic send_word(opcode_t op, logic [START_W-1:0] st, logic [LEN_W-1:0] cnt);
		int              gap;
		logic [IN_W-1:0] w;
		gap = pick_idle_len();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		w = '0;
		w[IN_BITS-1:0] = {cnt, st, op};
		s_tvalid <= 1'b1;
		s_tdata <= w;
		do @(posedge clk); while (!s_tready);
		ledger.note_word(op, st, cnt);
	endtask

	task automatic send_random_word();
		opcode_t          op;
		logic [START_W-1:0] st;
		logic [LEN_W-1:0]   cnt;
		int               append_odds;
		int               r;
		int               len;
		append_odds = (ledger.hole_count < 4) ? 65 : (ledger.hole_count >= HOLE_SLOTS) ? 30 : 45;
		r = $urandom_range(0, 99);
		if (r < append_odds) begin
			op = OP_APPEND;
		end else if (r < 88) begin
			op = OP_ALLOC;
		end else begin
			op = OP_QUERY;
		end
		st = ($urandom_range(0, 4) == 0) ? START_W'($urandom_range(1000, 1023))
		                                 : START_W'($urandom_range(0, 1023));
		r = $urandom_range(0, 99);
		if (op == OP_ALLOC) begin
			if (r < 60 && ledger.hole_count > 0) begin
				len = ledger.lengths[$urandom_range(0, ledger.hole_count - 1)];
				cnt = ($urandom_range(0, 2) == 0) ? LEN_W'(len) : LEN_W'($urandom_range(0, len));
			end else if (r < 85) begin
				cnt = LEN_W'($urandom_range(0, 40));
			end else begin
				cnt = LEN_W'($urandom_range(0, SWAP_PAGES));
			end
		end else begin
			if (r < 5) begin
				cnt = '0;
			end else if (r < 75) begin
				cnt = LEN_W'($urandom_range(1, 80));
			end else if (r < 95) begin
				cnt = LEN_W'($urandom_range(81, SWAP_PAGES));
			end else begin
				cnt = LEN_W'(SWAP_PAGES);
			end
		end
		send_word(op, st, cnt);
	endtask

	initial begin
		ledger = new();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_word(OP_QUERY, 10'd0, 11'd0);
		send_word(OP_ALLOC, 10'd0, 11'd1);
		send_word(OP_APPEND, 10'd0, 11'd0);
		send_word(OP_APPEND, 10'd1023, 11'd1024);
		send_word(OP_ALLOC, 10'd0, 11'd0);
		send_word(OP_ALLOC, 10'd0, 11'd100);
		send_word(OP_ALLOC, 10'd1023, 11'd1024);
		send_word(OP_APPEND, 10'd512, 11'd1024);
		send_word(OP_QUERY, 10'd1023, 11'd2047);
		for (int i = 0; i < HOLE_SLOTS - 2; i++) begin
			send_word(OP_APPEND, START_W'(i * 73), LEN_W'(i + 1));
		end
		send_word(OP_APPEND, 10'd5, 11'd7);
		send_word(OP_ALLOC, 10'd0, 11'd924);
		send_word(OP_ALLOC, 10'd0, 11'd1);

		for (int n = 0; n < RANDOM_WORDS; n++) begin
			if (n % 150 == 0) begin
				quiet = ($urandom_range(0, 3) == 0);
			end
			send_random_word();
		end
		quiet = 1'b0;
		s_tvalid <= 1'b0;

		while (ledger.pending_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (HOLE_SLOTS + 10) @(posedge clk);

		if (ledger.errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

>>> files.f
hw/rtl/ffha_pkg.sv
hw/rtl/ffha_dp.sv
hw/rtl/ffha_ctrl.sv
hw/rtl/first_fit_page_hole_allocator_top.sv
tb/tb_first_fit_page_hole_allocator_top.sv
